@@ rtl/core/tournament_tree_winner_count_unit_macros.svh @@
`ifndef TOURNAMENT_TREE_WINNER_COUNT_UNIT_MACROS_SVH
`define TOURNAMENT_TREE_WINNER_COUNT_UNIT_MACROS_SVH

// check the consequent in the same cycle
`define TWTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check the consequent in the cycle after the antecedent
`define TWTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/twtc_pkg.sv @@
package twtc_pkg;

    localparam int LEVELS      = 10;
    localparam int NODE_W      = LEVELS;
    localparam int NODE_COUNT  = 1 << LEVELS;
    localparam int CNT_W       = 11;
    localparam int OC_W        = 2;
    localparam int GAME_W      = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [OC_W-1:0] OC_LOWER    = 2'd0;
    localparam logic [OC_W-1:0] OC_UPPER    = 2'd1;
    localparam logic [OC_W-1:0] OC_UNKNOWN  = 2'd2;
    localparam logic [OC_W-1:0] OC_RESERVED = 2'd3;

    localparam logic [NODE_W-1:0] ROOT_NODE    = NODE_W'(1);
    localparam logic [CNT_W-1:0]  ROOT_RESET   = CNT_W'(NODE_COUNT);
    localparam logic [CNT_W-1:0]  LEAF_OPEN    = CNT_W'(2);
    localparam logic [CNT_W-1:0]  LEAF_DECIDED = CNT_W'(1);

    typedef struct packed {
        logic              oc_we;
        logic [NODE_W-1:0] oc_waddr;
        logic [OC_W-1:0]   oc_wdata;
        logic [NODE_W-1:0] oc_raddr;
        logic              cnt_we;
        logic [NODE_W-1:0] cnt_waddr;
        logic [CNT_W-1:0]  cnt_wdata;
        logic [NODE_W-1:0] cnt_raddr_l;
        logic [NODE_W-1:0] cnt_raddr_r;
    } mem_req_t;

    typedef struct packed {
        logic [OC_W-1:0]  oc;
        logic [CNT_W-1:0] cnt_l;
        logic [CNT_W-1:0] cnt_r;
    } mem_rsp_t;

    function automatic logic [CNT_W-1:0] node_value(
        input logic [OC_W-1:0]  oc,
        input logic             is_leaf,
        input logic [CNT_W-1:0] left,
        input logic [CNT_W-1:0] right
    );
        logic [CNT_W:0]   sum;
        logic [CNT_W-1:0] val;
        sum = {1'b0, left} + {1'b0, right};
        if (is_leaf) begin
            val = (oc == OC_UNKNOWN) ? LEAF_OPEN : LEAF_DECIDED;
        end else begin
            case (oc)
                OC_UPPER: val = left;
                OC_LOWER: val = right;
                default:  val = sum[CNT_W-1:0];
            endcase
        end
        return val;
    endfunction

endpackage

@@ rtl/core/twtc_store.sv @@
module twtc_store (
    input  logic               clk,
    input  twtc_pkg::mem_req_t req,
    output twtc_pkg::mem_rsp_t rsp
);
    import twtc_pkg::*;

    logic [OC_W-1:0]  oc_mem  [NODE_COUNT];
    logic [CNT_W-1:0] cnt_mem [NODE_COUNT];

    always_ff @(posedge clk) begin
        if (req.oc_we) begin
            oc_mem[req.oc_waddr] <= req.oc_wdata;
        end
        if (req.cnt_we) begin
            cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
        end
        rsp.oc    <= oc_mem[req.oc_raddr];
        rsp.cnt_l <= cnt_mem[req.cnt_raddr_l];
        rsp.cnt_r <= cnt_mem[req.cnt_raddr_r];
    end

endmodule

@@ rtl/core/twtc_walk.sv @@
`include "tournament_tree_winner_count_unit_macros.svh"

module twtc_walk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [twtc_pkg::GAME_W-1:0] in_game,
    input  logic [twtc_pkg::OC_W-1:0]   in_outcome,
    input  logic                        out_free,
    output logic                        res_valid,
    output logic [twtc_pkg::CNT_W-1:0]  res_data,
    output twtc_pkg::mem_req_t          mem_req,
    input  twtc_pkg::mem_rsp_t          mem_rsp
);
    import twtc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DONE} state_t;

    state_t            state_reg;
    logic [NODE_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]  clr_val_reg;
    logic [NODE_W-1:0] node_reg;
    logic [OC_W-1:0]   first_oc_reg;
    logic              first_reg;
    logic              from_right_reg;
    logic [CNT_W-1:0]  cur_val_reg;
    logic [CNT_W-1:0]  root_reg;

    logic              game_ok;
    logic [NODE_W-1:0] start_node;
    logic [OC_W-1:0]   oc_norm;
    logic [CNT_W-1:0]  left_val;
    logic [CNT_W-1:0]  right_val;
    logic [OC_W-1:0]   step_oc;
    logic [CNT_W-1:0]  step_val;
    logic              last_step;
    logic              clr_pow2;
    logic              accept;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign game_ok    = (in_game != '0) && (int'(in_game) < NODE_COUNT);
    assign start_node = NODE_W'(NODE_COUNT - int'(in_game));
    assign oc_norm    = (in_outcome == OC_RESERVED) ? OC_UNKNOWN : in_outcome;
    assign step_oc    = first_reg ? first_oc_reg : mem_rsp.oc;
    assign last_step  = (node_reg == ROOT_NODE);
    assign clr_pow2   = (clr_addr_reg & (clr_addr_reg - NODE_W'(1))) == '0;

    always_comb begin
        left_val  = mem_rsp.cnt_l;
        right_val = mem_rsp.cnt_r;
        if (!first_reg) begin
            if (from_right_reg) begin
                right_val = cur_val_reg;
            end else begin
                left_val = cur_val_reg;
            end
        end
        step_val = node_value(step_oc, node_reg[NODE_W-1], left_val, right_val);
    end

    always_comb begin
        res_valid = 1'b0;
        res_data  = root_reg;
        if (state_reg == ST_WALK && last_step && out_free) begin
            res_valid = 1'b1;
            res_data  = step_val;
        end else if (state_reg == ST_DONE && out_free) begin
            res_valid = 1'b1;
        end
    end

    always_comb begin
        mem_req = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_req.oc_we     = 1'b1;
                mem_req.oc_waddr  = clr_addr_reg;
                mem_req.oc_wdata  = OC_UNKNOWN;
                mem_req.cnt_we    = 1'b1;
                mem_req.cnt_waddr = clr_addr_reg;
                mem_req.cnt_wdata = clr_val_reg;
            end
            ST_IDLE: begin
                mem_req.oc_we       = accept && game_ok;
                mem_req.oc_waddr    = start_node;
                mem_req.oc_wdata    = oc_norm;
                mem_req.cnt_raddr_l = {start_node[NODE_W-2:0], 1'b0};
                mem_req.cnt_raddr_r = {start_node[NODE_W-2:0], 1'b1};
            end
            ST_WALK: begin
                mem_req.cnt_we      = 1'b1;
                mem_req.cnt_waddr   = node_reg;
                mem_req.cnt_wdata   = step_val;
                mem_req.oc_raddr    = node_reg >> 1;
                mem_req.cnt_raddr_l = {node_reg[NODE_W-1:1], 1'b0};
                mem_req.cnt_raddr_r = {node_reg[NODE_W-1:1], 1'b1};
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '1;
            clr_val_reg    <= LEAF_OPEN;
            root_reg       <= ROOT_RESET;
            first_reg      <= 1'b0;
            from_right_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg - NODE_W'(1);
                    if (clr_pow2) begin
                        clr_val_reg <= clr_val_reg << 1;
                    end
                    if (clr_addr_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        node_reg     <= start_node;
                        first_oc_reg <= oc_norm;
                        first_reg    <= 1'b1;
                        state_reg    <= game_ok ? ST_WALK : ST_DONE;
                    end
                end
                ST_WALK: begin
                    cur_val_reg    <= step_val;
                    first_reg      <= 1'b0;
                    from_right_reg <= node_reg[0];
                    node_reg       <= node_reg >> 1;
                    if (last_step) begin
                        root_reg  <= step_val;
                        state_reg <= out_free ? ST_IDLE : ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TWTC_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_reg == ST_CLEAR, !in_ready, "input taken during clear")
    `TWTC_ASSERT_NEXT(a_walk_after_start, clk, rst_n, accept && game_ok, state_reg == ST_WALK, "valid game did not start a walk")
    `TWTC_ASSERT_NOW(a_walk_count_range, clk, rst_n, state_reg == ST_WALK, step_val != '0 && step_val <= ROOT_RESET, "count out of range")
    `TWTC_ASSERT_NEXT(a_idle_after_result, clk, rst_n, res_valid, state_reg == ST_IDLE, "result issued without return to idle")

endmodule

@@ rtl/core/tournament_tree_winner_count_unit.sv @@
// Channel  Dir  Fields (lowest bit up)
// s_       in   tdata: game_number[9:0], outcome[11:10], zero pad to 16
// m_       out  tdata: possible_champions[10:0], zero pad to 16
//
// After reset a clearing pass writes all 1024 entries of both memories; s_tready stays low.
// An update walks from the game's node up to the root, with
// one read-modify-write of the count memory per tree level.
// A game_number of zero is out of range; it returns the current root count without a walk.
// A result waits in the output register; the walk holds at its end while it is occupied.
module tournament_tree_winner_count_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [twtc_pkg::IN_TDATA_W-1:0]      s_tdata,   // game_number, outcome
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [twtc_pkg::OUT_TDATA_W-1:0]     m_tdata    // possible_champions
);
    import twtc_pkg::*;

    mem_req_t         mem_req;
    mem_rsp_t         mem_rsp;
    logic             out_free;
    logic             res_valid;
    logic [CNT_W-1:0] res_data;
    logic             m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    twtc_walk u_walk (
        .clk        (aclk),
        .rst_n      (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_game    (s_tdata[GAME_W-1:0]),
        .in_outcome (s_tdata[GAME_W+OC_W-1:GAME_W]),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp)
    );

    twtc_store u_store (
        .clk (aclk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= OUT_TDATA_W'(res_data);
        end
    end

endmodule
